### rtl/cphc_pkg.sv
// ----------------------------------------------------------------------------
// cphc_pkg
// Shared types and constants for the compass peak homing controller: sizes
// of the averaging ring, field widths, step mode codes, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package cphc_pkg;

  // averaging ring, length is a power of two
  localparam int AVG_LOG     = 4;
  localparam int AVG_LEN     = 1 << AVG_LOG;
  localparam int PTR_W       = AVG_LOG;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_W       = SAMPLE_BITS + AVG_LOG + 1;
  localparam int AVG_W       = SAMPLE_BITS;
  localparam int FILL_W      = $clog2(AVG_LEN + 2);

  // register and result widths
  localparam int START_W = 20;
  localparam int HYST_W  = 8;
  localparam int THR_W   = 8;
  localparam int BAND_W  = 16;
  localparam int CNT_W   = 8;
  localparam int RATE_W  = 21;
  localparam int MODE_W  = 3;

  // width for signed compares of average, peak distance and bands
  localparam int CMP_W = ((AVG_W > BAND_W) ? AVG_W : BAND_W) + 2;

  // command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_FULL      = 3'd0,
    MODE_HALF      = 3'd1,
    MODE_QUARTER   = 3'd2,
    MODE_EIGHTH    = 3'd3,
    MODE_SIXTEENTH = 3'd4
  } mode_t;

  // configuration port
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int ADDR_W = IDX_W + 2;

  localparam logic [IDX_W-1:0] REG_START_RATE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HYSTERESIS  = 3'd1;
  localparam logic [IDX_W-1:0] REG_REV_THRESH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FINE_BAND   = 3'd3;
  localparam logic [IDX_W-1:0] REG_MID_BAND    = 3'd4;
  localparam logic [IDX_W-1:0] REG_COARSE_BAND = 3'd5;

  localparam logic [START_W-1:0] RST_START_RATE  = 20'd60000;
  localparam logic [HYST_W-1:0]  RST_HYSTERESIS  = 8'd1;
  localparam logic [THR_W-1:0]   RST_REV_THRESH  = 8'd3;
  localparam logic [BAND_W-1:0]  RST_FINE_BAND   = 16'd25;
  localparam logic [BAND_W-1:0]  RST_MID_BAND    = 16'd50;
  localparam logic [BAND_W-1:0]  RST_COARSE_BAND = 16'd100;

  typedef struct packed {
    logic [START_W-1:0] start_rate;
    logic [HYST_W-1:0]  hysteresis;
    logic [THR_W-1:0]   reversal_threshold;
    logic [BAND_W-1:0]  fine_band;
    logic [BAND_W-1:0]  mid_band;
    logic [BAND_W-1:0]  coarse_band;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/cphc_stream_if.sv
// ----------------------------------------------------------------------------
// cphc_stream_if
// Valid/ready channels of the homing controller: command words in, status
// words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cphc_in_if import cphc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, cmd, sample, input ready);
  modport sink (input valid, cmd, sample, output ready);
endinterface

interface cphc_out_if import cphc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] step_rate;
  mode_t                    step_mode;
  logic signed [AVG_W-1:0]  average;
  logic                     homed;
  logic                     busy_res;

  modport source (output valid, step_rate, step_mode, average, homed, busy_res,
                  input ready);
  modport sink (input valid, step_rate, step_mode, average, homed, busy_res,
                output ready);
endinterface

`default_nettype wire

### rtl/cphc_ram.sv
// ----------------------------------------------------------------------------
// cphc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cphc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/cphc_regs.sv
// ----------------------------------------------------------------------------
// cphc_regs
// Configuration register file behind an APB-style port, with readback.
// ----------------------------------------------------------------------------
`default_nettype none

module cphc_regs import cphc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:2];

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_rate         <= RST_START_RATE;
      cfg.hysteresis         <= RST_HYSTERESIS;
      cfg.reversal_threshold <= RST_REV_THRESH;
      cfg.fine_band          <= RST_FINE_BAND;
      cfg.mid_band           <= RST_MID_BAND;
      cfg.coarse_band        <= RST_COARSE_BAND;
    end else if (wr_en) begin
      unique case (idx)
        REG_START_RATE:  cfg.start_rate         <= pwdata[START_W-1:0];
        REG_HYSTERESIS:  cfg.hysteresis         <= pwdata[HYST_W-1:0];
        REG_REV_THRESH:  cfg.reversal_threshold <= pwdata[THR_W-1:0];
        REG_FINE_BAND:   cfg.fine_band          <= pwdata[BAND_W-1:0];
        REG_MID_BAND:    cfg.mid_band           <= pwdata[BAND_W-1:0];
        REG_COARSE_BAND: cfg.coarse_band        <= pwdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (idx)
      REG_START_RATE:  prdata = DATA_W'(cfg.start_rate);
      REG_HYSTERESIS:  prdata = DATA_W'(cfg.hysteresis);
      REG_REV_THRESH:  prdata = DATA_W'(cfg.reversal_threshold);
      REG_FINE_BAND:   prdata = DATA_W'(cfg.fine_band);
      REG_MID_BAND:    prdata = DATA_W'(cfg.mid_band);
      REG_COARSE_BAND: prdata = DATA_W'(cfg.coarse_band);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/cphc_core.sv
// ----------------------------------------------------------------------------
// cphc_core
// Homing datapath: ring read issue at accept, one compute stage that
// reads, modifies and writes back the sample ring and the run state, and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cphc_core import cphc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  cphc_in_if.sink                     din,
  cphc_out_if.source                  dout,
  output logic                        ram_re,
  output logic      [PTR_W-1:0]       ram_raddr,
  output logic                        ram_we,
  output logic      [PTR_W-1:0]       ram_waddr,
  output logic      [SAMPLE_BITS-1:0] ram_wdata,
  input  wire logic [SAMPLE_BITS-1:0] ram_rdata
);

  // issue side
  logic             accept;
  logic [PTR_W-1:0] ptr;

  // compute stage
  logic                          s1_valid;
  logic                          s1_cmd;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic [PTR_W-1:0]              s1_addr;
  logic                          s1_adv;

  // run state
  logic signed [SUM_W-1:0]  ring_sum, ring_sum_next;
  logic signed [AVG_W-1:0]  avg_now, avg_now_next;
  logic signed [AVG_W-1:0]  avg_peak, avg_peak_next;
  logic [FILL_W-1:0]        fill_count, fill_count_next;
  logic [CNT_W-1:0]         fall_count, fall_count_next;
  logic [CNT_W-1:0]         reversal_count, reversal_count_next;
  mode_t                    mode_now, mode_now_next;
  logic signed [RATE_W-1:0] rate_now, rate_now_next;
  logic                     running, running_next;
  logic                     finished, finished_next;
  logic [AVG_LEN-1:0]       ring_vld, ring_vld_next;

  // working values
  logic                          do_start;
  logic                          do_sample;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic signed [SUM_W-1:0]       sum_upd;
  logic signed [SUM_W-1:0]       sum_biased;
  logic signed [AVG_W-1:0]       avg_upd;
  logic signed [AVG_W-1:0]       peak_upd;
  logic [FILL_W-1:0]             fill_upd;
  logic                          ring_full;
  logic signed [CMP_W-1:0]       avg_x;
  logic signed [CMP_W-1:0]       avg_old_x;
  logic signed [CMP_W-1:0]       peak_x;
  logic signed [CMP_W-1:0]       hyst_x;
  logic signed [CMP_W-1:0]       peak_gap;
  logic signed [CMP_W-1:0]       fine_x;
  logic signed [CMP_W-1:0]       mid_x;
  logic signed [CMP_W-1:0]       coarse_x;
  logic                          fall_hit;
  logic [CNT_W-1:0]              fall_inc;
  logic                          rev_hit;
  logic [CNT_W-1:0]              rev_inc;

  // handshake: the compute stage moves on when the result register is free
  assign accept    = din.valid && din.ready;
  assign s1_adv    = s1_valid && (!dout.valid || dout.ready);
  assign din.ready = !s1_valid || s1_adv;

  // ring read issued with the word, pointer follows every sample word
  assign ram_re    = accept && (din.cmd == CMD_SAMPLE);
  assign ram_raddr = ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (accept) begin
      if (din.cmd == CMD_START) begin
        ptr <= '0;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // compute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd    <= din.cmd;
      s1_sample <= din.sample;
      s1_addr   <= ptr;
    end
  end

  // ring update and moving average, truncated toward zero
  always_comb begin
    do_start   = (s1_cmd == CMD_START);
    do_sample  = !do_start && running;
    old_sample = ring_vld[s1_addr] ? signed'(ram_rdata) : '0;
    sum_upd    = ring_sum - SUM_W'(old_sample) + SUM_W'(s1_sample);
    sum_biased = sum_upd[SUM_W-1] ? sum_upd + SUM_W'(AVG_LEN - 1) : sum_upd;
    avg_upd    = AVG_W'(sum_biased >>> AVG_LOG);
    peak_upd   = (avg_peak < avg_upd) ? avg_upd : avg_peak;
    fill_upd   = (fill_count <= FILL_W'(AVG_LEN)) ? fill_count + 1'b1 : fill_count;
    ring_full  = fill_upd > FILL_W'(AVG_LEN);
    avg_x      = CMP_W'(avg_upd);
    avg_old_x  = CMP_W'(avg_now);
    peak_x     = CMP_W'(peak_upd);
    hyst_x     = signed'(CMP_W'(cfg.hysteresis));
    peak_gap   = peak_x - avg_x;
    fine_x     = signed'(CMP_W'(cfg.fine_band));
    mid_x      = signed'(CMP_W'(cfg.mid_band));
    coarse_x   = signed'(CMP_W'(cfg.coarse_band));
    fall_hit   = ring_full && (mode_now == MODE_FULL) && (avg_x + hyst_x < avg_old_x);
    fall_inc   = fall_count + 1'b1;
    rev_hit    = fall_inc > cfg.reversal_threshold;
    rev_inc    = rev_hit ? reversal_count + 1'b1 : reversal_count;
  end

  // next run state
  always_comb begin
    ring_sum_next       = ring_sum;
    avg_now_next        = avg_now;
    avg_peak_next       = avg_peak;
    fill_count_next     = fill_count;
    fall_count_next     = fall_count;
    reversal_count_next = reversal_count;
    mode_now_next       = mode_now;
    rate_now_next       = rate_now;
    running_next        = running;
    finished_next       = finished;
    ring_vld_next       = ring_vld;
    if (do_start) begin
      ring_sum_next       = '0;
      avg_now_next        = '0;
      avg_peak_next       = '0;
      fill_count_next     = '0;
      fall_count_next     = '0;
      reversal_count_next = '0;
      mode_now_next       = MODE_FULL;
      rate_now_next       = RATE_W'(cfg.start_rate);
      running_next        = 1'b1;
      finished_next       = 1'b0;
      ring_vld_next       = '0;
    end else if (do_sample) begin
      ring_sum_next          = sum_upd;
      avg_now_next           = avg_upd;
      avg_peak_next          = peak_upd;
      fill_count_next        = fill_upd;
      ring_vld_next[s1_addr] = 1'b1;
      // falls in full stepping: reverse, and every second reversal go to half
      if (fall_hit) begin
        fall_count_next = fall_inc;
        if (rev_hit) begin
          rate_now_next   = -rate_now;
          fill_count_next = '0;
        end
        if (!rev_inc[0] && (rev_inc != '0)) begin
          mode_now_next       = MODE_HALF;
          reversal_count_next = '0;
        end else begin
          reversal_count_next = rev_inc;
        end
      end else if (mode_now == MODE_FULL) begin
        fall_count_next = '0;
      end else if (ring_full) begin
        // microstep choice from distance to the peak
        if (peak_gap < fine_x && peak_gap > -fine_x) begin
          mode_now_next = MODE_SIXTEENTH;
        end else if (peak_gap < mid_x && peak_gap > -mid_x) begin
          mode_now_next = MODE_EIGHTH;
        end else if (peak_gap < coarse_x && peak_gap > -coarse_x) begin
          mode_now_next = MODE_QUARTER;
        end
      end
      // homed test
      if (mode_now_next == MODE_SIXTEENTH && avg_x + hyst_x > peak_x &&
          avg_x - hyst_x < peak_x) begin
        running_next  = 1'b0;
        finished_next = 1'b1;
        rate_now_next = '0;
      end
    end
  end

  // ring write back
  assign ram_we    = s1_adv && do_sample;
  assign ram_waddr = s1_addr;
  assign ram_wdata = s1_sample;

  // run state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_sum       <= '0;
      avg_now        <= '0;
      avg_peak       <= '0;
      fill_count     <= '0;
      fall_count     <= '0;
      reversal_count <= '0;
      mode_now       <= MODE_FULL;
      rate_now       <= '0;
      running        <= 1'b0;
      finished       <= 1'b0;
      ring_vld       <= '0;
    end else if (s1_adv) begin
      ring_sum       <= ring_sum_next;
      avg_now        <= avg_now_next;
      avg_peak       <= avg_peak_next;
      fill_count     <= fill_count_next;
      fall_count     <= fall_count_next;
      reversal_count <= reversal_count_next;
      mode_now       <= mode_now_next;
      rate_now       <= rate_now_next;
      running        <= running_next;
      finished       <= finished_next;
      ring_vld       <= ring_vld_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (s1_adv) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      dout.step_rate <= running_next ? rate_now_next : '0;
      dout.step_mode <= mode_now_next;
      dout.average   <= avg_now_next;
      dout.homed     <= finished_next;
      dout.busy_res  <= running_next;
    end
  end

endmodule

`default_nettype wire

### rtl/compass_peak_homing_controller_top.sv
// ----------------------------------------------------------------------------
// compass_peak_homing_controller_top
// Stepper homing sequencer that seeks the peak of a magnetometer axis from
// a moving average of its samples.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              word
//   din      in   din.valid / din.ready  cmd, sample
//   dout     out  dout.valid/dout.ready  step_rate, step_mode, average,
//                                        homed, busy_res
//   apb      in   psel, penable, pwrite  paddr, pwdata (prdata on reads)
//
// One word per cycle unless a held result stalls the input; the ring read
// is registered with the compute stage, which feeds the result register.
// The ring is written back as the word leaves the compute stage; a stalled
// result register holds the compute stage and so the input.
// Synchronous reset; no clearing pass, ring entries carry valid bits that a
// start word clears at once.
// ----------------------------------------------------------------------------
`default_nettype none

module compass_peak_homing_controller_top import cphc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  cphc_in_if.sink                din,
  cphc_out_if.source             dout,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t                   cfg;
  logic                   ram_re;
  logic [PTR_W-1:0]       ram_raddr;
  logic                   ram_we;
  logic [PTR_W-1:0]       ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // configuration registers
  cphc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sample ring
  cphc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (AVG_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // homing datapath
  cphc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .din       (din),
    .dout      (dout),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  // write back never meets a read of the same ring entry
  a_ring_no_collide: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("ring write and read hit the same entry");

  // the input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !din.ready |-> dout.valid && !dout.ready)
    else $error("input stalled with the result side free");

  // a homed result is stopped in sixteenth stepping
  a_homed_state: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.homed |->
      dout.step_mode == MODE_SIXTEENTH && dout.step_rate == '0 && !dout.busy_res)
    else $error("homed result with motion or wrong mode");

  // no rate command outside a run
  a_idle_rate: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.busy_res |-> dout.step_rate == '0)
    else $error("rate commanded while idle");

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the compass peak homing controller. A software
// copy of the homing sequencer follows every word taken on the command
// channel and the status words that come back are compared field by field.
// Stimulus is a short directed opening, then synthetic magnetometer sweeps
// (rising and falling legs that settle near their highest reading), mixed
// with noise and broken runs, under several register settings, with random
// stalls on both channels and one long stall on the status side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import cphc_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 110;
  localparam int PHASES       = 8;
  localparam int SAMPLE_MAX   = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SAMPLE_MIN   = -SAMPLE_MAX - 1;
  localparam logic [START_W-1:0] START_MAX = '1;

  // index with no register behind it
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd6;

  typedef struct {
    logic signed [RATE_W-1:0] rate;
    mode_t                    mode;
    logic signed [AVG_W-1:0]  avg;
    logic                     homed;
    logic                     busy;
  } status_t;

  // software copy of the homing sequencer and the status words it owes
  class homing_tracker;
    logic [START_W-1:0] start_rate;
    logic [HYST_W-1:0]  hysteresis;
    logic [THR_W-1:0]   rev_thresh;
    logic [BAND_W-1:0]  fine_band;
    logic [BAND_W-1:0]  mid_band;
    logic [BAND_W-1:0]  coarse_band;

    longint            ring [AVG_LEN];
    longint            ring_sum, avg_now, avg_before, avg_peak, rate_now;
    int                fill_count, ring_pos;
    logic [CNT_W-1:0]  fall_count, rev_count;
    mode_t             mode_now;
    bit                running, finished;

    status_t           pending[$];
    int                failures;

    function new();
      start_rate  = RST_START_RATE;
      hysteresis  = RST_HYSTERESIS;
      rev_thresh  = RST_REV_THRESH;
      fine_band   = RST_FINE_BAND;
      mid_band    = RST_MID_BAND;
      coarse_band = RST_COARSE_BAND;
      clear_run();
      running  = 1'b0;
      finished = 1'b0;
      failures = 0;
    endfunction

    function void clear_run();
      foreach (ring[i]) ring[i] = 0;
      ring_sum   = 0;
      avg_now    = 0;
      avg_before = 0;
      avg_peak   = 0;
      fill_count = 0;
      ring_pos   = 0;
      fall_count = '0;
      rev_count  = '0;
      mode_now   = MODE_FULL;
      rate_now   = 0;
    endfunction

    function void set_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      case (idx)
        REG_START_RATE:  start_rate  = val[START_W-1:0];
        REG_HYSTERESIS:  hysteresis  = val[HYST_W-1:0];
        REG_REV_THRESH:  rev_thresh  = val[THR_W-1:0];
        REG_FINE_BAND:   fine_band   = val[BAND_W-1:0];
        REG_MID_BAND:    mid_band    = val[BAND_W-1:0];
        REG_COARSE_BAND: coarse_band = val[BAND_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the sequencer by one command word and queue its status word
    function void take_word(input logic cmd, input logic signed [SAMPLE_BITS-1:0] smp);
      mode_t   mode_was;
      longint  h, gap, fb, mb, cb;
      int      p;
      status_t st;
      if (cmd == CMD_START) begin
        clear_run();
        rate_now = start_rate;
        running  = 1'b1;
        finished = 1'b0;
      end else if (running) begin
        mode_was = mode_now;
        h        = hysteresis;
        p        = ring_pos;
        // ring update and moving average, truncated toward zero
        ring_sum   = ring_sum - ring[p] + smp;
        ring[p]    = smp;
        avg_before = avg_now;
        avg_now    = ring_sum / AVG_LEN;
        if (avg_peak < avg_now) avg_peak = avg_now;
        if (fill_count <= AVG_LEN) fill_count++;
        if (fill_count > AVG_LEN && mode_was == MODE_FULL && avg_now + h < avg_before) begin
          // fall in full stepping, counter wraps and survives a reversal
          fall_count++;
          if (fall_count > rev_thresh) begin
            rate_now   = -rate_now;
            rev_count++;
            fill_count = 0;
          end
          if (rev_count[0] == 1'b0 && rev_count != '0) begin
            mode_now  = MODE_HALF;
            rev_count = '0;
          end
        end else if (mode_was == MODE_FULL) begin
          fall_count = '0;
        end else if (fill_count > AVG_LEN) begin
          // peak distance at full width against the bands
          gap = avg_peak - avg_now;
          fb  = fine_band;
          mb  = mid_band;
          cb  = coarse_band;
          if (gap < fb && gap > -fb) mode_now = MODE_SIXTEENTH;
          else if (gap < mb && gap > -mb) mode_now = MODE_EIGHTH;
          else if (gap < cb && gap > -cb) mode_now = MODE_QUARTER;
        end
        ring_pos = (p + 1) % AVG_LEN;
        // homed once sixteenth stepping sits strictly inside the margin
        if (mode_now == MODE_SIXTEENTH && avg_now + h > avg_peak && avg_now - h < avg_peak) begin
          running  = 1'b0;
          finished = 1'b1;
          rate_now = 0;
        end
      end
      st.rate  = running ? rate_now[RATE_W-1:0] : '0;
      st.mode  = mode_now;
      st.avg   = avg_now[AVG_W-1:0];
      st.homed = finished;
      st.busy  = running;
      pending.push_back(st);
    endfunction

    function void check_status(input logic signed [RATE_W-1:0] rate, input mode_t mode,
                               input logic signed [AVG_W-1:0] avg, input logic homed,
                               input logic busy);
      status_t want;
      if (pending.size() == 0) begin
        $display("%0t: status word with nothing owed: rate %0d mode %0d avg %0d",
                 $time, rate, mode, avg);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (rate !== want.rate) begin
        $display("%0t: step_rate expected %0d, got %0d", $time, want.rate, rate);
        failures++;
      end
      if (mode !== want.mode) begin
        $display("%0t: step_mode expected %0d, got %0d", $time, want.mode, mode);
        failures++;
      end
      if (avg !== want.avg) begin
        $display("%0t: average expected %0d, got %0d", $time, want.avg, avg);
        failures++;
      end
      if (homed !== want.homed) begin
        $display("%0t: homed expected %0b, got %0b", $time, want.homed, homed);
        failures++;
      end
      if (busy !== want.busy) begin
        $display("%0t: busy_res expected %0b, got %0b", $time, want.busy, busy);
        failures++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cphc_in_if  din();
  cphc_out_if dout();

  homing_tracker tracker = new();

  int src_idle_pct = 17;
  int snk_idle_pct = 83;
  int words_sent   = 0;
  int cycle_count  = 0;
  bit hold_req     = 1'b0;

  compass_peak_homing_controller_top uut (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .dout    (dout),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // words taken on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (dout.valid && dout.ready)
        tracker.check_status(dout.step_rate, dout.step_mode, dout.average, dout.homed,
                             dout.busy_res);
      if (din.valid && din.ready) tracker.take_word(din.cmd, din.sample);
    end
  end

  // status side: random stalls, plus one long hold-off on request
  initial begin
    dout.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          dout.ready <= 1'b0;
          @(negedge clk);
        end
      end
      dout.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  function automatic int clamp_sample(input int v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // offer one command word, called and returning at a falling edge
  task automatic send_word(input logic cmd, input logic signed [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      din.valid <= 1'b0;
      @(negedge clk);
    end
    din.valid  <= 1'b1;
    din.cmd    <= cmd;
    din.sample <= smp;
    do @(posedge clk); while (!din.ready);
    words_sent++;
    @(negedge clk);
  endtask

  // one register write, bus left idle afterwards
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // all six registers, junk above each field to check the masking
  task automatic set_cfg(input logic [START_W-1:0] sr, input logic [HYST_W-1:0] hy,
                         input logic [THR_W-1:0] th, input logic [BAND_W-1:0] fb,
                         input logic [BAND_W-1:0] mb, input logic [BAND_W-1:0] cb);
    write_reg(REG_START_RATE,  (DATA_W'($urandom) << START_W) | sr);
    write_reg(REG_HYSTERESIS,  (DATA_W'($urandom) << HYST_W) | hy);
    write_reg(REG_REV_THRESH,  (DATA_W'($urandom) << THR_W) | th);
    write_reg(REG_FINE_BAND,   (DATA_W'($urandom) << BAND_W) | fb);
    write_reg(REG_MID_BAND,    (DATA_W'($urandom) << BAND_W) | mb);
    write_reg(REG_COARSE_BAND, (DATA_W'($urandom) << BAND_W) | cb);
  endtask

  // stop offering, wait until every owed status word is back, let the pipe settle
  task automatic wait_drained();
    din.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int quota, lvl, step, noise, dir, top, v, fb, mb;
    rst        = 1'b1;
    din.valid  = 1'b0;
    din.cmd    = CMD_SAMPLE;
    din.sample = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      // idling pattern: sender light and receiver heavy, then swapped, then none
      case (phase / 3)
        0: begin
          src_idle_pct = 17;
          snk_idle_pct = 83;
        end
        1: begin
          src_idle_pct = 83;
          snk_idle_pct = 17;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase

      if (phase > 0) wait_drained();
      case (phase)
        0: begin
          // samples while idle are ignored
          send_word(CMD_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX));
          send_word(CMD_SAMPLE, SAMPLE_BITS'(SAMPLE_MIN));
          send_word(CMD_START, '1);
          // small negative sums truncate toward zero
          send_word(CMD_SAMPLE, '1);
          send_word(CMD_SAMPLE, SAMPLE_BITS'(-15));
          send_word(CMD_SAMPLE, '0);
          send_word(CMD_SAMPLE, SAMPLE_BITS'(1));
          repeat (3) send_word(CMD_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX));
          repeat (4) send_word(CMD_SAMPLE, SAMPLE_BITS'(SAMPLE_MIN));
          send_word(CMD_SAMPLE, 16'h5555);
          send_word(CMD_SAMPLE, 16'haaaa);
          // restart in the middle of a run
          send_word(CMD_START, SAMPLE_BITS'(SAMPLE_MAX));
          repeat (6) send_word(CMD_SAMPLE, SAMPLE_BITS'(SAMPLE_MIN));
        end
        1: set_cfg(START_MAX, '0, '0, '0, '0, '0);
        2: set_cfg('0, '1, '1, '1, '1, '1);
        3: set_cfg(START_MAX, 8'd1, '0, '1, '1, '1);
        7: set_cfg(RST_START_RATE, RST_HYSTERESIS, RST_REV_THRESH, RST_FINE_BAND,
                   RST_MID_BAND, RST_COARSE_BAND);
        default: begin
          fb = $urandom_range(1, 200);
          mb = fb + $urandom_range(0, 300);
          set_cfg(START_W'($urandom), HYST_W'($urandom_range(0, 6)),
                  THR_W'($urandom_range(0, 5)), BAND_W'(fb), BAND_W'(mb),
                  BAND_W'(mb + $urandom_range(0, 600)));
          if (phase == 4) write_reg(REG_SPARE, $urandom);
        end
      endcase

      // long status stall with the sender still pushing
      if (phase == 6) hold_req = 1'b1;

      quota = words_sent + PHASE_WORDS;
      while (words_sent < quota) begin
        case ($urandom_range(0, 9))
          0, 1: repeat ($urandom_range(1, 12))
            send_word(($urandom_range(0, 5) == 0) ? CMD_START : CMD_SAMPLE,
                      SAMPLE_BITS'($urandom));
          2: begin
            // run cut short by a restart or left hanging
            send_word(CMD_START, SAMPLE_BITS'($urandom));
            repeat ($urandom_range(3, 30)) send_word(CMD_SAMPLE, SAMPLE_BITS'($urandom));
          end
          default: begin
            // sweep past the field peak a few times, then settle near the top
            lvl   = int'($urandom_range(0, 40000)) - 20000;
            step  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4000)
                                                : $urandom_range(1, 400);
            noise = $urandom_range(0, step / 2);
            dir   = $urandom_range(0, 1) ? 1 : -1;
            top   = 0;
            send_word(CMD_START, SAMPLE_BITS'($urandom));
            repeat ($urandom_range(2, 5)) begin
              repeat ($urandom_range(18, 40)) begin
                lvl = clamp_sample(lvl + dir * step);
                v   = clamp_sample(lvl + int'($urandom_range(0, 2 * noise)) - noise);
                if (v > top) top = v;
                send_word(CMD_SAMPLE, SAMPLE_BITS'(v));
              end
              dir = -dir;
            end
            v = clamp_sample(top - int'($urandom_range(0, 40)));
            repeat ($urandom_range(18, 36)) send_word(CMD_SAMPLE, SAMPLE_BITS'(v));
          end
        endcase
      end
    end

    wait_drained();
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
